// ----- src/cfi_pkg.sv -----
// ----------------------------------------------------------------------------
// cfi_pkg
// Shared constants, tables and types of the copy-flag image unpacker.
// ----------------------------------------------------------------------------
package cfi_pkg;

  // storage sizing
  localparam int MAX_UNITS  = 256;
  localparam int RING_LINES = 17;
  localparam int COL_W      = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int PAIR_W     = COL_W + 1;
  localparam int SLOT_W     = $clog2(RING_LINES);
  localparam int HIST_AW    = SLOT_W + PAIR_W;
  localparam int HIST_DEPTH = RING_LINES * (2 ** PAIR_W);

  // field widths
  localparam int FLAG_W    = 8;
  localparam int NIBBLE_W  = 4;
  localparam int PAIR_DW   = 16;
  localparam int UNITS_W   = 9;
  localparam int LINE_W    = 16;
  localparam int TAKEN_W   = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DW    = 16;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // copy offset tables, indexed by the flag nibble
  localparam logic [3:0] LEFT_BYTES [16] = '{
    4'd0, 4'd2, 4'd4, 4'd8, 4'd0, 4'd2, 4'd0, 4'd2,
    4'd4, 4'd0, 4'd2, 4'd4, 4'd0, 4'd2, 4'd4, 4'd0
  };
  localparam logic [4:0] UP_LINES [16] = '{
    5'd0, 5'd0, 5'd0, 5'd0, 5'd1, 5'd1, 5'd2, 5'd2,
    5'd2, 5'd4, 5'd4, 5'd4, 5'd8, 5'd8, 5'd8, 5'd16
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UNITS_PER_LINE = 1'b0,
    CFG_IMAGE_HEIGHT   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic              en;
    logic              clear;
    logic [COL_W-1:0]  col;
    logic [FLAG_W-1:0] data;
  } flag_wr_t;

  typedef struct packed {
    logic               en;
    logic [HIST_AW-1:0] addr;
    logic [PAIR_DW-1:0] data;
  } hist_wr_t;

  typedef struct packed {
    logic               image_end;
    logic               line_end;
    logic               bad_reference;
    logic               flag_byte_taken;
    logic [TAKEN_W-1:0] pairs_taken;
    logic [PAIR_DW-1:0] right_pair;
    logic [PAIR_DW-1:0] left_pair;
  } out_item_t;

endpackage

// ----- src/cfi_flag_row.sv -----
// ----------------------------------------------------------------------------
// cfi_flag_row
// Per-column flag byte memory with one valid bit per column; an image end
// drops all valid bits so the row reads as zero again.
// ----------------------------------------------------------------------------
module cfi_flag_row (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [cfi_pkg::COL_W-1:0]    rd_col_i,
  input  cfi_pkg::flag_wr_t            wr_i,
  output logic [cfi_pkg::FLAG_W-1:0]   rd_data_o
);
  import cfi_pkg::*;

  logic [FLAG_W-1:0]    mem [MAX_UNITS];
  logic [MAX_UNITS-1:0] valid_q, valid_d;
  logic [FLAG_W-1:0]    rd_q;
  logic                 rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.col] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_col_i];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (wr_i.clear) begin
      valid_d = '0;
    end else if (wr_i.en) begin
      valid_d[wr_i.col] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_col_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule

// ----- src/cfi_history.sv -----
// ----------------------------------------------------------------------------
// cfi_history
// Ring of stored lines as byte pairs: one write and one read port, read
// data registered, with a bypass when a read meets a write to the same pair.
// ----------------------------------------------------------------------------
module cfi_history (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [cfi_pkg::HIST_AW-1:0]   rd_addr_i,
  input  cfi_pkg::hist_wr_t             wr_i,
  output logic [cfi_pkg::PAIR_DW-1:0]   rd_data_o
);
  import cfi_pkg::*;

  logic [PAIR_DW-1:0] mem [HIST_DEPTH];
  logic [PAIR_DW-1:0] rd_q;
  logic [PAIR_DW-1:0] fwd_data_q;
  logic               fwd_hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
    fwd_data_q <= wr_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else begin
      fwd_hit_q <= rd_en_i && wr_i.en && (rd_addr_i == wr_i.addr);
    end
  end

  assign rd_data_o = fwd_hit_q ? fwd_data_q : rd_q;

endmodule

// ----- src/cfi_out_fifo.sv -----
// ----------------------------------------------------------------------------
// cfi_out_fifo
// Small result queue between the pipeline and the output stream.
// ----------------------------------------------------------------------------
module cfi_out_fifo (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  cfi_pkg::out_item_t               push_item_i,
  input  logic                             pop_i,
  output logic                             valid_o,
  output cfi_pkg::out_item_t               item_o,
  output logic [cfi_pkg::FIFO_CNT_W-1:0]   count_o
);
  import cfi_pkg::*;

  out_item_t             mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_item_i;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign item_o  = mem[rd_ptr_q];
  assign count_o = cnt_q;

endmodule

// ----- src/copy_flag_image_unpacker.sv -----
// ----------------------------------------------------------------------------
// copy_flag_image_unpacker
// A unit passes stages 1, 2 and 3 and the result queue before it is sent out.
// Input waits while stage 1 is busy or the queue lacks room. Each unit makes
// two reads and two writes on the line memory, with one read and one write port.
// Reset: position counters to zero, registers to 80 units and 400 lines,
// flag row reads as zero; line memory contents stay undefined until written.
// ----------------------------------------------------------------------------
module copy_flag_image_unpacker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cfi_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [cfi_pkg::CFG_DW-1:0]      cfg_data_i,
  // input units
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [7:0] flag_b_byte, [23:8] first_literal_pair, [39:24] second_literal_pair
  input  logic [39:0]                     s_axis_tdata_i,
  // [0] flag_a_bit
  input  logic [0:0]                      s_axis_tuser_i,
  // results
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [15:0] left_pair, [31:16] right_pair
  output logic [31:0]                     m_axis_tdata_o,
  // [1:0] pairs_taken, [2] flag_byte_taken, [3] bad_reference, [4] image_end
  output logic [4:0]                      m_axis_tuser_o,
  // line_end
  output logic                            m_axis_tlast_o
);
  import cfi_pkg::*;

  localparam int UCMP_W = (COL_W + 1 > UNITS_W) ? COL_W + 1 : UNITS_W;

  function automatic logic [HIST_AW-1:0] copy_addr(
    input logic [SLOT_W-1:0]   ring,
    input logic [PAIR_W-1:0]   p,
    input logic [NIBBLE_W-1:0] code
  );
    logic [2:0]        dx;
    logic [SLOT_W:0]   dy;
    logic [SLOT_W:0]   slot;
    dx = LEFT_BYTES[code][3:1];
    dy = (SLOT_W + 1)'(UP_LINES[code]);
    if ({1'b0, ring} >= dy) begin
      slot = {1'b0, ring} - dy;
    end else begin
      slot = {1'b0, ring} + (SLOT_W + 1)'(RING_LINES) - dy;
    end
    return {slot[SLOT_W-1:0], p - PAIR_W'(dx)};
  endfunction

  function automatic logic copy_bad(
    input logic [LINE_W-1:0]   line,
    input logic [PAIR_W-1:0]   p,
    input logic [NIBBLE_W-1:0] code
  );
    logic [2:0] dx;
    dx = LEFT_BYTES[code][3:1];
    return (code != '0) &&
           ((p < PAIR_W'(dx)) || (line < LINE_W'(UP_LINES[code])));
  endfunction

  // configuration and position
  logic [UNITS_W-1:0] units_q;
  logic [LINE_W-1:0]  height_q;
  logic [COL_W-1:0]   col_q, col_d;
  logic [LINE_W-1:0]  line_q, line_d;
  logic [SLOT_W-1:0]  ring_q, ring_d;
  logic [UCMP_W-1:0]  col_next;
  logic [LINE_W:0]    line_next;
  logic               pos_line_end, pos_image_end;
  logic               accept;

  // stage 1: flag update, left read issue
  logic                 s1_valid_q;
  logic                 s1_a_q;
  logic [FLAG_W-1:0]    s1_b_q;
  logic [PAIR_DW-1:0]   s1_lit0_q, s1_lit1_q;
  logic [COL_W-1:0]     s1_col_q;
  logic [LINE_W-1:0]    s1_line_q;
  logic [SLOT_W-1:0]    s1_ring_q;
  logic                 s1_line_end_q, s1_image_end_q;
  logic [FLAG_W-1:0]    flag_rd, flag_cur;
  logic [NIBBLE_W-1:0]  s1_lcode;
  logic [PAIR_W-1:0]    s1_lp;

  // stage 2: left pair resolved, right read issue
  logic                 s2_valid_q;
  logic                 s2_a_q;
  logic [PAIR_DW-1:0]   s2_lit0_q, s2_lit1_q;
  logic [COL_W-1:0]     s2_col_q;
  logic [LINE_W-1:0]    s2_line_q;
  logic [SLOT_W-1:0]    s2_ring_q;
  logic                 s2_line_end_q, s2_image_end_q;
  logic [FLAG_W-1:0]    s2_flag_q;
  logic                 s2_lbad_q;
  logic [NIBBLE_W-1:0]  s2_lcode, s2_rcode;
  logic [PAIR_W-1:0]    s2_rp;
  logic [PAIR_DW-1:0]   s2_left;
  logic                 s2_rbad;

  // stage 3: right pair resolved, result pushed
  logic                 s3_valid_q;
  logic                 s3_a_q;
  logic [PAIR_DW-1:0]   s3_left_q, s3_rlit_q;
  logic [COL_W-1:0]     s3_col_q;
  logic [SLOT_W-1:0]    s3_ring_q;
  logic                 s3_line_end_q, s3_image_end_q;
  logic                 s3_lbad_q, s3_rbad_q, s3_rlit_sel_q;
  logic [TAKEN_W-1:0]   s3_taken_q;
  logic [PAIR_DW-1:0]   s3_right;

  flag_wr_t             flag_wr;
  hist_wr_t             hist_wr;
  logic                 hist_rd_en;
  logic [HIST_AW-1:0]   hist_rd_addr;
  logic [PAIR_DW-1:0]   hist_rd;

  out_item_t             push_item, head_item;
  logic                  fifo_valid, fifo_pop;
  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic [FIFO_CNT_W-1:0] pending;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      units_q  <= UNITS_W'(80);
      height_q <= LINE_W'(400);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_UNITS_PER_LINE: units_q  <= cfg_data_i[UNITS_W-1:0];
        CFG_IMAGE_HEIGHT:   height_q <= cfg_data_i[LINE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- accept
  // results in flight plus queued must fit the queue
  assign pending = fifo_cnt + FIFO_CNT_W'(s2_valid_q) + FIFO_CNT_W'(s3_valid_q);
  assign s_axis_tready_o = !s1_valid_q && (pending < FIFO_CNT_W'(FIFO_DEPTH));
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  // a zero register compares as one, a large one as the memory limit
  assign col_next      = UCMP_W'(col_q) + 1'b1;
  assign line_next     = {1'b0, line_q} + 1'b1;
  assign pos_line_end  = (col_next >= UCMP_W'(units_q)) ||
                         (col_next >= UCMP_W'(MAX_UNITS));
  assign pos_image_end = pos_line_end && (line_next >= {1'b0, height_q});

  always_comb begin
    col_d  = col_q;
    line_d = line_q;
    ring_d = ring_q;
    if (accept) begin
      if (pos_line_end) begin
        col_d = '0;
        if (pos_image_end) begin
          line_d = '0;
          ring_d = '0;
        end else begin
          line_d = line_next[LINE_W-1:0];
          ring_d = (ring_q == SLOT_W'(RING_LINES - 1)) ? '0 : ring_q + 1'b1;
        end
      end else begin
        col_d = col_next[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      line_q <= '0;
      ring_q <= '0;
    end else begin
      col_q  <= col_d;
      line_q <= line_d;
      ring_q <= ring_d;
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_a_q         <= s_axis_tuser_i[0];
      s1_b_q         <= s_axis_tdata_i[7:0];
      s1_lit0_q      <= s_axis_tdata_i[23:8];
      s1_lit1_q      <= s_axis_tdata_i[39:24];
      s1_col_q       <= col_q;
      s1_line_q      <= line_q;
      s1_ring_q      <= ring_q;
      s1_line_end_q  <= pos_line_end;
      s1_image_end_q <= pos_image_end;
    end
  end

  cfi_flag_row u_flag_row (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_col_i  (col_q),
    .wr_i      (flag_wr),
    .rd_data_o (flag_rd)
  );

  assign flag_cur = flag_rd ^ (s1_a_q ? s1_b_q : '0);
  assign s1_lcode = flag_cur[FLAG_W-1 -: NIBBLE_W];
  assign s1_lp    = {s1_col_q, 1'b0};

  always_comb begin
    flag_wr       = '0;
    flag_wr.en    = s1_valid_q;
    flag_wr.clear = s1_valid_q && s1_image_end_q;
    flag_wr.col   = s1_col_q;
    flag_wr.data  = flag_cur;
  end

  // ---------------------------------------------------------------- stage 2
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_a_q         <= s1_a_q;
      s2_lit0_q      <= s1_lit0_q;
      s2_lit1_q      <= s1_lit1_q;
      s2_col_q       <= s1_col_q;
      s2_line_q      <= s1_line_q;
      s2_ring_q      <= s1_ring_q;
      s2_line_end_q  <= s1_line_end_q;
      s2_image_end_q <= s1_image_end_q;
      s2_flag_q      <= flag_cur;
      s2_lbad_q      <= copy_bad(s1_line_q, s1_lp, s1_lcode);
    end
  end

  assign s2_lcode = s2_flag_q[FLAG_W-1 -: NIBBLE_W];
  assign s2_rcode = s2_flag_q[NIBBLE_W-1:0];
  assign s2_rp    = {s2_col_q, 1'b1};
  assign s2_rbad  = copy_bad(s2_line_q, s2_rp, s2_rcode);

  always_comb begin
    if (s2_lcode == '0) begin
      s2_left = s2_lit0_q;
    end else if (s2_lbad_q) begin
      s2_left = '0;
    end else begin
      s2_left = hist_rd;
    end
  end

  // ---------------------------------------------------------------- stage 3
  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      s3_a_q         <= s2_a_q;
      s3_left_q      <= s2_left;
      // right literal is the second pair when the left half took the first
      s3_rlit_q      <= (s2_lcode == '0) ? s2_lit1_q : s2_lit0_q;
      s3_rlit_sel_q  <= (s2_rcode == '0);
      s3_col_q       <= s2_col_q;
      s3_ring_q      <= s2_ring_q;
      s3_line_end_q  <= s2_line_end_q;
      s3_image_end_q <= s2_image_end_q;
      s3_lbad_q      <= s2_lbad_q;
      s3_rbad_q      <= s2_rbad;
      s3_taken_q     <= TAKEN_W'(s2_lcode == '0) + TAKEN_W'(s2_rcode == '0);
    end
  end

  always_comb begin
    if (s3_rlit_sel_q) begin
      s3_right = s3_rlit_q;
    end else if (s3_rbad_q) begin
      s3_right = '0;
    end else begin
      s3_right = hist_rd;
    end
  end

  // ---------------------------------------------------------------- stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // ---------------------------------------------------------------- line memory
  // stages 1/2 never overlap, nor do stages 2/3, so one port each suffices
  assign hist_rd_en   = s1_valid_q || s2_valid_q;
  assign hist_rd_addr = s1_valid_q ? copy_addr(s1_ring_q, s1_lp, s1_lcode)
                                   : copy_addr(s2_ring_q, s2_rp, s2_rcode);

  always_comb begin
    hist_wr    = '0;
    hist_wr.en = s2_valid_q || s3_valid_q;
    if (s2_valid_q) begin
      hist_wr.addr = {s2_ring_q, s2_col_q, 1'b0};
      hist_wr.data = s2_left;
    end else begin
      hist_wr.addr = {s3_ring_q, s3_col_q, 1'b1};
      hist_wr.data = s3_right;
    end
  end

  cfi_history u_history (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (hist_rd_en),
    .rd_addr_i (hist_rd_addr),
    .wr_i      (hist_wr),
    .rd_data_o (hist_rd)
  );

  // ---------------------------------------------------------------- output
  always_comb begin
    push_item                 = '0;
    push_item.image_end       = s3_image_end_q;
    push_item.line_end        = s3_line_end_q;
    push_item.bad_reference   = s3_lbad_q || s3_rbad_q;
    push_item.flag_byte_taken = s3_a_q;
    push_item.pairs_taken     = s3_taken_q;
    push_item.right_pair      = s3_right;
    push_item.left_pair       = s3_left_q;
  end

  assign fifo_pop = fifo_valid && m_axis_tready_i;

  cfi_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s3_valid_q),
    .push_item_i (push_item),
    .pop_i       (fifo_pop),
    .valid_o     (fifo_valid),
    .item_o      (head_item),
    .count_o     (fifo_cnt)
  );

  assign m_axis_tvalid_o = fifo_valid;
  assign m_axis_tdata_o  = {head_item.right_pair, head_item.left_pair};
  assign m_axis_tuser_o  = {head_item.image_end, head_item.bad_reference,
                            head_item.flag_byte_taken, head_item.pairs_taken};
  assign m_axis_tlast_o  = head_item.line_end;

endmodule

// ----- src/cfi_checker.sv -----
// ----------------------------------------------------------------------------
// cfi_checker
// Port-level checks of the unpacker, bound to the top level.
// ----------------------------------------------------------------------------
module cfi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [4:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // image end only ever falls on a line end
  a_image_end_on_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[4] |-> m_axis_tlast_o)
    else $error("image end without line end");

  // at most two literal pairs per unit
  a_pairs_taken_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o[1:0] != 2'd3))
    else $error("pairs taken out of range");

  // no new unit is accepted straight after an accepted one
  a_input_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input beat taken on consecutive cycles");

  // a stalled result beat holds
  a_output_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result beat changed");

endmodule

bind copy_flag_image_unpacker cfi_checker u_cfi_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// ----- tb/sv/cfi_result_checker.sv -----
// ----------------------------------------------------------------------------
// cfi_result_checker
// Watches the configuration, unit and result channels of the copy-flag image
// unpacker. Holds its own flag row, line history and position, predicts every
// result beat and compares it against what the block sends out.
// ----------------------------------------------------------------------------
module cfi_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [cfi_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [cfi_pkg::CFG_DW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [39:0]                   in_data_i,
  input  logic [0:0]                    in_user_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [31:0]                   out_data_i,
  input  logic [4:0]                    out_user_i,
  input  logic                          out_last_i,
  output int                            mismatch_count_o,
  output int                            pending_o,
  output logic                          image_start_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import cfi_pkg::*;

  localparam int LINE_PAIRS  = 2 * MAX_UNITS;
  localparam int MAX_REPORTS = 10;
  // copy offsets per flag nibble: pairs to the left, lines up
  localparam int unsigned PAIR_STEP [16] = '{0, 1, 2, 4, 0, 1, 0, 1, 2, 0, 1, 2, 0, 1, 2, 0};
  localparam int unsigned LINES_UP  [16] = '{0, 0, 0, 0, 1, 1, 2, 2, 2, 4, 4, 4, 8, 8, 8, 16};

  logic [UNITS_W-1:0] units_cfg;
  logic [LINE_W-1:0]  height_cfg;
  logic [FLAG_W-1:0]  flag_row [MAX_UNITS];
  logic [PAIR_DW-1:0] pair_history [RING_LINES * LINE_PAIRS];
  int unsigned        column;
  int unsigned        line_no;
  int unsigned        ring_slot;
  out_item_t          predicted_units [$];
  out_item_t          next_unit;
  out_item_t          seen;
  out_item_t          wanted;
  int                 mismatches;

  function automatic int unsigned line_units();
    if (units_cfg == '0) return 1;
    if (units_cfg > MAX_UNITS) return MAX_UNITS;
    return units_cfg;
  endfunction

  function automatic int unsigned image_lines();
    return (height_cfg == '0) ? 1 : height_cfg;
  endfunction

  task automatic decode_unit(input logic a_bit, input logic [FLAG_W-1:0] b_byte,
                             input logic [PAIR_DW-1:0] lit_first,
                             input logic [PAIR_DW-1:0] lit_second,
                             output out_item_t res);
    logic [PAIR_DW-1:0]  lits [2];
    logic [PAIR_DW-1:0]  pairs [2];
    logic [FLAG_W-1:0]   flag;
    logic [NIBBLE_W-1:0] code;
    logic                bad;
    int unsigned         taken;
    int unsigned         p;
    int unsigned         dx;
    int unsigned         dy;
    int unsigned         src;
    lits[0] = lit_first;
    lits[1] = lit_second;
    taken   = 0;
    bad     = 1'b0;
    if (a_bit) flag_row[column] = flag_row[column] ^ b_byte;
    flag = flag_row[column];
    // left pair is stored first, so the right one may copy it
    for (int half = 0; half < 2; half++) begin
      code = half ? flag[3:0] : flag[7:4];
      p    = column * 2 + half;
      if (code == '0) begin
        pairs[half] = lits[taken];
        taken++;
      end else begin
        dx = PAIR_STEP[code];
        dy = LINES_UP[code];
        if (p < dx || line_no < dy) begin
          bad         = 1'b1;
          pairs[half] = '0;
        end else begin
          src = ((ring_slot + RING_LINES - dy) % RING_LINES) * LINE_PAIRS + p - dx;
          pairs[half] = pair_history[src];
        end
      end
      pair_history[ring_slot * LINE_PAIRS + p] = pairs[half];
    end
    res.left_pair       = pairs[0];
    res.right_pair      = pairs[1];
    res.pairs_taken     = TAKEN_W'(taken);
    res.flag_byte_taken = a_bit;
    res.bad_reference   = bad;
    res.line_end        = 1'b0;
    res.image_end       = 1'b0;
    // a shrunk limit ends the line or image on this unit
    if (column + 1 >= line_units()) begin
      res.line_end = 1'b1;
      column       = 0;
      if (line_no + 1 >= image_lines()) begin
        res.image_end = 1'b1;
        line_no       = 0;
        ring_slot     = 0;
        foreach (flag_row[i]) flag_row[i] = '0;
      end else begin
        line_no++;
        ring_slot = (ring_slot + 1) % RING_LINES;
      end
    end else begin
      column++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      units_cfg  = UNITS_W'(80);
      height_cfg = LINE_W'(400);
      foreach (flag_row[i]) flag_row[i] = '0;
      column     = 0;
      line_no    = 0;
      ring_slot  = 0;
      mismatches = 0;
      predicted_units.delete();
      mismatch_count_o <= 0;
      pending_o        <= 0;
      image_start_o    <= 1'b1;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_UNITS_PER_LINE: units_cfg = cfg_data_i[UNITS_W-1:0];
          CFG_IMAGE_HEIGHT:   height_cfg = cfg_data_i[LINE_W-1:0];
          default: ;
        endcase
      end
      // results first, so a beat can never match a unit taken at the same edge
      if (out_valid_i && out_ready_i) begin
        seen.left_pair       = out_data_i[15:0];
        seen.right_pair      = out_data_i[31:16];
        seen.pairs_taken     = out_user_i[1:0];
        seen.flag_byte_taken = out_user_i[2];
        seen.bad_reference   = out_user_i[3];
        seen.image_end       = out_user_i[4];
        seen.line_end        = out_last_i;
        if (predicted_units.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result beat with nothing predicted: left %h right %h user %b",
                     $realtime, seen.left_pair, seen.right_pair, out_user_i);
        end else begin
          wanted = predicted_units.pop_front();
          if (seen !== wanted) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: mismatch", $realtime);
              $display("  expected left %h right %h taken %0d flag %b bad %b ends %b %b",
                       wanted.left_pair, wanted.right_pair, wanted.pairs_taken,
                       wanted.flag_byte_taken, wanted.bad_reference,
                       wanted.line_end, wanted.image_end);
              $display("  actual   left %h right %h taken %0d flag %b bad %b ends %b %b",
                       seen.left_pair, seen.right_pair, seen.pairs_taken,
                       seen.flag_byte_taken, seen.bad_reference,
                       seen.line_end, seen.image_end);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        decode_unit(in_user_i[0], in_data_i[7:0], in_data_i[23:8], in_data_i[39:24],
                    next_unit);
        predicted_units.push_back(next_unit);
      end
      mismatch_count_o <= mismatches;
      pending_o        <= predicted_units.size();
      image_start_o    <= (column == 0 && line_no == 0);
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the copy-flag image unpacker with a short directed frame, a walk
// through every copy code, then random frames under changing line widths and
// heights, with bursty input and a stalling result sink.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cfi_pkg::*;

  localparam int RANDOM_UNITS = 1300;
  localparam int DRAIN_CYCLES = 12;
  localparam int TIMEOUT_NS   = 1_000_000;

  typedef enum int {RX_ALWAYS, RX_HALF, RX_QUARTER, RX_RHYTHM} rx_pattern_e;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [CFG_DW-1:0]    cfg_data      = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [39:0]          s_axis_tdata  = '0;
  logic [0:0]           s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;
  logic [4:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  int                   mismatch_count;
  int                   pending_units;
  logic                 image_start;

  int                   burst_left = 0;
  int                   cur_units  = 80;
  int                   sent_units = 0;
  rx_pattern_e          rx_mode    = RX_ALWAYS;
  int                   rx_left    = 0;
  int                   rx_tick    = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  copy_flag_image_unpacker u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  cfi_result_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_i       (s_axis_tready),
    .in_data_i        (s_axis_tdata),
    .in_user_i        (s_axis_tuser),
    .out_valid_i      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_data_i       (m_axis_tdata),
    .out_user_i       (m_axis_tuser),
    .out_last_i       (m_axis_tlast),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_units),
    .image_start_o    (image_start)
  );

  // result sink: switches between stall patterns every so often
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_pattern_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_ALWAYS:  m_axis_tready <= 1'b1;
      RX_HALF:    m_axis_tready <= 1'($urandom_range(0, 1));
      RX_QUARTER: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:    m_axis_tready <= (rx_tick % 5 != 0);
    endcase
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // bits above the width field are ignored by the block, so they carry noise
  task automatic write_units(input logic [UNITS_W-1:0] val);
    write_reg(CFG_UNITS_PER_LINE, {(CFG_DW-UNITS_W)'($urandom), val});
    cur_units = (val == '0) ? 1 : ((val > MAX_UNITS) ? MAX_UNITS : int'(val));
  endtask

  function automatic logic [LINE_W-1:0] pick_height();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return LINE_W'($urandom_range(1, 16));
      4:       return LINE_W'($urandom);
      default: return LINE_W'($urandom_range(17, 48));
    endcase
  endfunction

  task automatic send_unit(input logic a_bit, input logic [FLAG_W-1:0] b_byte,
                           input logic [PAIR_DW-1:0] lit_first,
                           input logic [PAIR_DW-1:0] lit_second);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 7);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {lit_second, lit_first, b_byte};
    s_axis_tuser  <= a_bit;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  // block idle: input low and every predicted beat seen
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_units != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [FLAG_W-1:0]   col_flag;
    logic [FLAG_W-1:0]   want_flag;
    logic [NIBBLE_W-1:0] code;
    logic [UNITS_W-1:0]  uv;
    int                  n;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // two units a line, three lines: literals, in-line copies, up copy,
    // references off the left edge and above the image
    write_units(UNITS_W'(2));
    write_reg(CFG_IMAGE_HEIGHT, 16'd3);
    cfg_valid <= 1'b0;
    send_unit(1'b0, 8'h00, 16'hFFFF, 16'h0000);
    send_unit(1'b1, 8'h10, 16'h1234, 16'hABCD);
    send_unit(1'b1, 8'h40, 16'h5A5A, 16'hA5A5);
    send_unit(1'b1, 8'h31, 16'h0F0F, 16'hF0F0);
    send_unit(1'b1, 8'h33, 16'h8001, 16'h7FFE);
    send_unit(1'b1, 8'hFF, 16'hC3C3, 16'h3C3C);
    settle();

    // one unit a line over seventeen lines, both nibbles walking every code,
    // so the sixteen-lines-up copy lands on the last line
    write_units('0);
    write_reg(CFG_IMAGE_HEIGHT, 16'd17);
    cfg_valid <= 1'b0;
    col_flag = '0;
    for (int k = 0; k < 17; k++) begin
      code      = NIBBLE_W'(k + 15);
      want_flag = {code, code};
      send_unit(1'b1, want_flag ^ col_flag, PAIR_DW'($urandom), PAIR_DW'($urandom));
      col_flag  = want_flag;
    end

    while (sent_units < RANDOM_UNITS) begin
      settle();
      if (image_start) begin
        case ($urandom_range(0, 9))
          0:       uv = '0;
          1:       uv = UNITS_W'(MAX_UNITS);
          2:       uv = UNITS_W'($urandom_range(MAX_UNITS + 1, 511));
          3:       uv = UNITS_W'($urandom_range(17, MAX_UNITS - 1));
          4, 5, 6: uv = UNITS_W'($urandom_range(1, 4));
          default: uv = UNITS_W'($urandom_range(5, 16));
        endcase
        write_units(uv);
        write_reg(CFG_IMAGE_HEIGHT, pick_height());
      end else if ($urandom_range(0, 1)) begin
        // mid-image the width only shrinks, so copies never reach unwritten history
        if ($urandom_range(0, 1)) begin
          uv = UNITS_W'($urandom_range(0, cur_units));
          if (cur_units == MAX_UNITS && $urandom_range(0, 1))
            uv = UNITS_W'($urandom_range(MAX_UNITS + 1, 511));
          write_units(uv);
        end
        if ($urandom_range(0, 1)) write_reg(CFG_IMAGE_HEIGHT, pick_height());
      end
      cfg_valid <= 1'b0;
      n = $urandom_range(20, 160);
      repeat (n) begin
        send_unit($urandom_range(0, 99) < 60, FLAG_W'($urandom), PAIR_DW'($urandom),
                  PAIR_DW'($urandom));
      end
      sent_units += n;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_units == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- copy_flag_image_unpacker.f -----
src/cfi_pkg.sv
src/cfi_flag_row.sv
src/cfi_history.sv
src/cfi_out_fifo.sv
src/copy_flag_image_unpacker.sv
src/cfi_checker.sv
tb/sv/cfi_result_checker.sv
tb/sv/testbench.sv
